/* design/dmprt_pkg.sv */
// ----------------------------------------------------------------------------
// dmprt_pkg
// shared types and constants of the dual-modulus polynomial root test block
// ----------------------------------------------------------------------------
package dmprt_pkg;

    localparam int R1_W       = 25;
    localparam int R2_W       = 30;
    localparam int POINT_W    = 20;
    localparam int IDX_W      = 7;
    localparam int DIGIT_W    = 4;
    localparam int STEP_CNT_W = 5;

    localparam int unsigned PRIME_FIRST  = 19260817;
    localparam int unsigned PRIME_SECOND = 998244353;

    localparam logic [DIGIT_W-1:0] RADIX = 4'd10;

    localparam logic CMD_DIGIT = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic               command;
        logic [IDX_W-1:0]   coeff_index;
        logic [DIGIT_W-1:0] digit;
        logic               first_digit;
        logic               last_digit;
        logic               negative;
        logic [POINT_W-1:0] point;
    } in_item_t;

    typedef struct packed {
        logic [POINT_W-1:0] evaluated_point;
        logic               is_root;
        logic [R1_W-1:0]    residue_first;
        logic [R2_W-1:0]    residue_second;
    } out_item_t;

    typedef struct packed {
        logic [R1_W-1:0] first;
        logic [R2_W-1:0] second;
    } coeff_t;

    typedef enum logic [2:0] {
        MM_HOLD,
        MM_LOAD,
        MM_ADD,
        MM_MUL_START,
        MM_STEP
    } mm_op_t;

    typedef struct packed {
        mm_op_t op;
        logic   mbit;
    } mm_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_LOAD,
        ST_D_MSTART,
        ST_D_STEP,
        ST_D_ADD,
        ST_D_STORE,
        ST_E_CLEAR,
        ST_E_ADD,
        ST_E_MSTART,
        ST_E_STEP,
        ST_E_LAST,
        ST_E_DONE
    } state_t;

endpackage

/* design/dual_modulus_polynomial_root_test.sv */
// digit transfer: accepted in idle, then load, multiply by radix, add and store
// evaluate: clear, add and multiply per coefficient, last add, result registered
// rate is set by the bit-serial modular multiplier, one bit of x per cycle
// per horner step, both primes in parallel lanes
// rst_n asynchronous active low clears control, running residues and degree
// coefficient memory is not cleared, no startup pass
// ----------------------------------------------------------------------------
// dual_modulus_polynomial_root_test
// horner evaluation of a stored polynomial modulo two primes, root flag
// ----------------------------------------------------------------------------
module dual_modulus_polynomial_root_test #(
    parameter int MAX_COEFFS = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  dmprt_pkg::in_item_t         in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output dmprt_pkg::out_item_t        out_item,
    input  logic                        cfg_write_en,
    input  logic [dmprt_pkg::IDX_W-1:0] cfg_write_data
);

    localparam int AW = $clog2(MAX_COEFFS);

    dmprt_pkg::mm_ctrl_t        lane_ctrl;
    logic [dmprt_pkg::R1_W-1:0] load_first;
    logic [dmprt_pkg::R2_W-1:0] load_second;
    logic [dmprt_pkg::R1_W-1:0] add_first;
    logic [dmprt_pkg::R2_W-1:0] add_second;
    logic [dmprt_pkg::R1_W-1:0] r_first;
    logic [dmprt_pkg::R2_W-1:0] r_second;
    logic [dmprt_pkg::R1_W-1:0] r_first_neg;
    logic [dmprt_pkg::R2_W-1:0] r_second_neg;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    dmprt_pkg::coeff_t          wr_data;
    logic [AW-1:0]              rd_addr;
    dmprt_pkg::coeff_t          rd_data;

    dmprt_seq #(
        .MAX_COEFFS(MAX_COEFFS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .lane_ctrl      (lane_ctrl),
        .load_first     (load_first),
        .load_second    (load_second),
        .add_first      (add_first),
        .add_second     (add_second),
        .r_first        (r_first),
        .r_second       (r_second),
        .r_first_neg    (r_first_neg),
        .r_second_neg   (r_second_neg),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    dmprt_lane #(
        .W(dmprt_pkg::R1_W),
        .P(dmprt_pkg::PRIME_FIRST)
    ) u_lane_first (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .load_val (load_first),
        .add_val  (add_first),
        .r        (r_first),
        .r_neg    (r_first_neg)
    );

    dmprt_lane #(
        .W(dmprt_pkg::R2_W),
        .P(dmprt_pkg::PRIME_SECOND)
    ) u_lane_second (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .load_val (load_second),
        .add_val  (add_second),
        .r        (r_second),
        .r_neg    (r_second_neg)
    );

    dmprt_coeff_store #(
        .DEPTH(MAX_COEFFS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* design/dmprt_lane.sv */
// ----------------------------------------------------------------------------
// dmprt_lane
// shared modular add / bit-serial modular multiply unit for one prime
// ----------------------------------------------------------------------------
module dmprt_lane #(
    parameter int          W = 25,
    parameter int unsigned P = 19260817
) (
    input  logic               clk,
    input  dmprt_pkg::mm_ctrl_t ctrl,
    input  logic [W-1:0]       load_val,
    input  logic [W-1:0]       add_val,
    output logic [W-1:0]       r,
    output logic [W-1:0]       r_neg
);

    localparam logic [W:0] PW = (W+1)'(P);

    logic [W-1:0] r_reg;
    logic [W-1:0] r_next;
    logic [W-1:0] a_reg;
    logic [W-1:0] a_next;
    logic [W:0]   sum;
    logic [W:0]   dbl;
    logic [W:0]   dbl_red;
    logic [W:0]   step_sum;

    always_comb
    begin
        r_next   = r_reg;
        a_next   = a_reg;
        sum      = {1'b0, r_reg} + {1'b0, add_val};
        dbl      = {r_reg, 1'b0};
        dbl_red  = (dbl >= PW) ? dbl - PW : dbl;
        step_sum = dbl_red + (ctrl.mbit ? {1'b0, a_reg} : '0);
        case (ctrl.op)
            dmprt_pkg::MM_LOAD:
            begin
                r_next = load_val;
            end
            dmprt_pkg::MM_ADD:
            begin
                r_next = (sum >= PW) ? W'(sum - PW) : W'(sum);
            end
            dmprt_pkg::MM_MUL_START:
            begin
                a_next = r_reg;
                r_next = '0;
            end
            dmprt_pkg::MM_STEP:
            begin
                r_next = (step_sum >= PW) ? W'(step_sum - PW) : W'(step_sum);
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
    end

    assign r     = r_reg;
    assign r_neg = (r_reg == '0) ? '0 : W'(PW - {1'b0, r_reg});

endmodule

/* design/dmprt_coeff_store.sv */
// ----------------------------------------------------------------------------
// dmprt_coeff_store
// coefficient residue memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module dmprt_coeff_store #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  dmprt_pkg::coeff_t        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output dmprt_pkg::coeff_t        rd_data
);

    dmprt_pkg::coeff_t mem [DEPTH];
    dmprt_pkg::coeff_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/dmprt_seq.sv */
// ----------------------------------------------------------------------------
// dmprt_seq
// sequencer: digit folding, coefficient store, horner walk and result register
// ----------------------------------------------------------------------------
module dmprt_seq #(
    parameter int MAX_COEFFS = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dmprt_pkg::in_item_t           in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dmprt_pkg::out_item_t          out_item,
    input  logic                          cfg_write_en,
    input  logic [dmprt_pkg::IDX_W-1:0]   cfg_write_data,
    output dmprt_pkg::mm_ctrl_t           lane_ctrl,
    output logic [dmprt_pkg::R1_W-1:0]    load_first,
    output logic [dmprt_pkg::R2_W-1:0]    load_second,
    output logic [dmprt_pkg::R1_W-1:0]    add_first,
    output logic [dmprt_pkg::R2_W-1:0]    add_second,
    input  logic [dmprt_pkg::R1_W-1:0]    r_first,
    input  logic [dmprt_pkg::R2_W-1:0]    r_second,
    input  logic [dmprt_pkg::R1_W-1:0]    r_first_neg,
    input  logic [dmprt_pkg::R2_W-1:0]    r_second_neg,
    output logic                          wr_en,
    output logic [$clog2(MAX_COEFFS)-1:0] wr_addr,
    output dmprt_pkg::coeff_t             wr_data,
    output logic [$clog2(MAX_COEFFS)-1:0] rd_addr,
    input  dmprt_pkg::coeff_t             rd_data
);

    localparam int AW = $clog2(MAX_COEFFS);
    localparam logic [31:0] TOP_MAX = 32'(MAX_COEFFS - 1);

    dmprt_pkg::state_t   state_reg;
    dmprt_pkg::state_t   state_next;
    dmprt_pkg::in_item_t item_reg;
    dmprt_pkg::in_item_t item_next;
    logic [dmprt_pkg::R1_W-1:0]       running_first_reg;
    logic [dmprt_pkg::R1_W-1:0]       running_first_next;
    logic [dmprt_pkg::R2_W-1:0]       running_second_reg;
    logic [dmprt_pkg::R2_W-1:0]       running_second_next;
    logic [dmprt_pkg::IDX_W-1:0]      degree_reg;
    logic [dmprt_pkg::IDX_W-1:0]      degree_next;
    logic [AW-1:0]                    j_reg;
    logic [AW-1:0]                    j_next;
    logic [dmprt_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic [dmprt_pkg::STEP_CNT_W-1:0] cnt_next;
    logic [dmprt_pkg::POINT_W-1:0]    mult_reg;
    logic [dmprt_pkg::POINT_W-1:0]    mult_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    dmprt_pkg::out_item_t             out_item_reg;
    dmprt_pkg::out_item_t             out_item_next;

    logic [31:0] deg_ext;
    logic [31:0] top_ext;
    logic [31:0] idx_ext;
    logic        idx_ok;

    assign deg_ext = 32'(degree_reg);
    assign top_ext = (deg_ext >= TOP_MAX) ? TOP_MAX : deg_ext;
    assign idx_ext = 32'(item_reg.coeff_index);
    assign idx_ok  = (idx_ext < 32'(MAX_COEFFS));

    assign rd_addr        = j_reg;
    assign wr_addr        = idx_ext[AW-1:0];
    assign wr_data.first  = item_reg.negative ? r_first_neg : r_first;
    assign wr_data.second = item_reg.negative ? r_second_neg : r_second;

    always_comb
    begin
        state_next          = state_reg;
        item_next           = item_reg;
        running_first_next  = running_first_reg;
        running_second_next = running_second_reg;
        degree_next         = degree_reg;
        j_next              = j_reg;
        cnt_next            = cnt_reg;
        mult_next           = mult_reg;
        out_valid_next      = out_valid_reg;
        out_item_next       = out_item_reg;
        lane_ctrl.op        = dmprt_pkg::MM_HOLD;
        lane_ctrl.mbit      = mult_reg[dmprt_pkg::POINT_W-1];
        load_first          = '0;
        load_second         = '0;
        add_first           = '0;
        add_second          = '0;
        wr_en               = 1'b0;
        in_ready            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_write_en)
        begin
            degree_next = cfg_write_data;
        end

        case (state_reg)
            dmprt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_item;
                    if (in_item.command == dmprt_pkg::CMD_EVAL)
                    begin
                        j_next     = top_ext[AW-1:0];
                        state_next = dmprt_pkg::ST_E_CLEAR;
                    end
                    else
                    begin
                        state_next = dmprt_pkg::ST_D_LOAD;
                    end
                end
            end
            dmprt_pkg::ST_D_LOAD:
            begin
                lane_ctrl.op = dmprt_pkg::MM_LOAD;
                load_first   = item_reg.first_digit ? '0 : running_first_reg;
                load_second  = item_reg.first_digit ? '0 : running_second_reg;
                state_next   = dmprt_pkg::ST_D_MSTART;
            end
            dmprt_pkg::ST_D_MSTART:
            begin
                lane_ctrl.op = dmprt_pkg::MM_MUL_START;
                mult_next    = {dmprt_pkg::RADIX,
                                {(dmprt_pkg::POINT_W - dmprt_pkg::DIGIT_W){1'b0}}};
                cnt_next     = dmprt_pkg::STEP_CNT_W'(dmprt_pkg::DIGIT_W);
                state_next   = dmprt_pkg::ST_D_STEP;
            end
            dmprt_pkg::ST_D_STEP:
            begin
                lane_ctrl.op = dmprt_pkg::MM_STEP;
                mult_next    = mult_reg << 1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == dmprt_pkg::STEP_CNT_W'(1))
                begin
                    state_next = dmprt_pkg::ST_D_ADD;
                end
            end
            dmprt_pkg::ST_D_ADD:
            begin
                lane_ctrl.op = dmprt_pkg::MM_ADD;
                add_first    = dmprt_pkg::R1_W'(item_reg.digit);
                add_second   = dmprt_pkg::R2_W'(item_reg.digit);
                state_next   = dmprt_pkg::ST_D_STORE;
            end
            dmprt_pkg::ST_D_STORE:
            begin
                running_first_next  = r_first;
                running_second_next = r_second;
                wr_en               = item_reg.last_digit && idx_ok;
                state_next          = dmprt_pkg::ST_IDLE;
            end
            dmprt_pkg::ST_E_CLEAR:
            begin
                lane_ctrl.op = dmprt_pkg::MM_LOAD;
                state_next   = (j_reg == '0) ? dmprt_pkg::ST_E_LAST : dmprt_pkg::ST_E_ADD;
            end
            dmprt_pkg::ST_E_ADD:
            begin
                lane_ctrl.op = dmprt_pkg::MM_ADD;
                add_first    = rd_data.first;
                add_second   = rd_data.second;
                state_next   = dmprt_pkg::ST_E_MSTART;
            end
            dmprt_pkg::ST_E_MSTART:
            begin
                lane_ctrl.op = dmprt_pkg::MM_MUL_START;
                mult_next    = item_reg.point;
                cnt_next     = dmprt_pkg::STEP_CNT_W'(dmprt_pkg::POINT_W);
                j_next       = j_reg - 1'b1;
                state_next   = dmprt_pkg::ST_E_STEP;
            end
            dmprt_pkg::ST_E_STEP:
            begin
                lane_ctrl.op = dmprt_pkg::MM_STEP;
                mult_next    = mult_reg << 1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == dmprt_pkg::STEP_CNT_W'(1))
                begin
                    state_next = (j_reg == '0) ? dmprt_pkg::ST_E_LAST : dmprt_pkg::ST_E_ADD;
                end
            end
            dmprt_pkg::ST_E_LAST:
            begin
                lane_ctrl.op = dmprt_pkg::MM_ADD;
                add_first    = rd_data.first;
                add_second   = rd_data.second;
                state_next   = dmprt_pkg::ST_E_DONE;
            end
            dmprt_pkg::ST_E_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_item_next.evaluated_point = item_reg.point;
                    out_item_next.is_root         = (r_first == '0) || (r_second == '0);
                    out_item_next.residue_first   = r_first;
                    out_item_next.residue_second  = r_second;
                    state_next                    = dmprt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmprt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= dmprt_pkg::ST_IDLE;
            running_first_reg  <= '0;
            running_second_reg <= '0;
            degree_reg         <= '0;
            j_reg              <= '0;
            cnt_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            running_first_reg  <= running_first_next;
            running_second_reg <= running_second_next;
            degree_reg         <= degree_next;
            j_reg              <= j_next;
            cnt_reg            <= cnt_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        mult_reg     <= mult_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* design/dmprt_checker.sv */
// ----------------------------------------------------------------------------
// dmprt_checker
// port-level checks of the dual-modulus polynomial root test block
// ----------------------------------------------------------------------------
module dmprt_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input dmprt_pkg::out_item_t out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // residues stay normalized
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_item.residue_first) < dmprt_pkg::PRIME_FIRST) &&
                      (32'(out_item.residue_second) < dmprt_pkg::PRIME_SECOND))
        else $error("residue out of range");

    // root flag matches residues
    a_root_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.is_root ==
                      ((out_item.residue_first == '0) || (out_item.residue_second == '0)))
        else $error("root flag mismatch");

    // busy after every transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after transfer");

endmodule

bind dual_modulus_polynomial_root_test dmprt_checker u_checker (.*);

/* tb/tb_dual_modulus_polynomial_root_test.sv */
// ----------------------------------------------------------------------------
// tb_dual_modulus_polynomial_root_test
// digit loading and horner evaluation checked against a two-prime bench model
// ----------------------------------------------------------------------------
module tb_dual_modulus_polynomial_root_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_COEFFS    = 128;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 1500;
    localparam int STALL_LIMIT   = 20000;
    localparam int SHOW_LIMIT    = 10;
    localparam int NUM_PHASES    = 16;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    dmprt_pkg::in_item_t            in_item;
    logic                           out_valid;
    logic                           out_ready;
    dmprt_pkg::out_item_t           out_item;
    logic                           cfg_write_en;
    logic [dmprt_pkg::IDX_W-1:0]    cfg_write_data;

    // bench copy of the block state
    logic [dmprt_pkg::IDX_W-1:0]    degree_q;
    logic [dmprt_pkg::R1_W-1:0]     run_r1;
    logic [dmprt_pkg::R2_W-1:0]     run_r2;
    logic [dmprt_pkg::R1_W-1:0]     coeff_r1 [NUM_COEFFS];
    logic [dmprt_pkg::R2_W-1:0]     coeff_r2 [NUM_COEFFS];
    bit                             coeff_loaded [NUM_COEFFS];

    dmprt_pkg::out_item_t           pending_results [$];
    int                             fail_count = 0;
    bit                             idle_on = 1'b1;
    bit                             hold_req = 1'b0;

    always #CLK_HALF clk = ~clk;

    dual_modulus_polynomial_root_test #(
        .MAX_COEFFS(NUM_COEFFS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    function automatic longint unsigned fold_digit(input longint unsigned acc,
                                                   input longint unsigned d,
                                                   input longint unsigned p);
        return (acc * 64'(dmprt_pkg::RADIX) + d) % p;
    endfunction

    function automatic longint unsigned negate_mod(input longint unsigned r,
                                                   input longint unsigned p);
        return (r == 0) ? 0 : p - r;
    endfunction

    function automatic longint unsigned horner_mod(input bit lane_first, input int top,
                                                   input longint unsigned x);
        longint unsigned p;
        longint unsigned xr;
        longint unsigned acc;
        longint unsigned c;
        p   = lane_first ? 64'(dmprt_pkg::PRIME_FIRST) : 64'(dmprt_pkg::PRIME_SECOND);
        xr  = x % p;
        acc = 0;
        for (int j = top; j >= 1; j--)
        begin
            c   = lane_first ? 64'(coeff_r1[j]) : 64'(coeff_r2[j]);
            acc = ((c + acc) % p) * xr % p;
        end
        c = lane_first ? 64'(coeff_r1[0]) : 64'(coeff_r2[0]);
        return (acc + c) % p;
    endfunction

    function automatic logic [dmprt_pkg::DIGIT_W-1:0] rand_digit();
        if ($urandom_range(0, 7) == 0)
            return dmprt_pkg::DIGIT_W'($urandom_range(10, 15));
        return dmprt_pkg::DIGIT_W'($urandom_range(0, 9));
    endfunction

    task automatic apply_item(input dmprt_pkg::in_item_t it);
        longint unsigned      r1;
        longint unsigned      r2;
        dmprt_pkg::out_item_t want;
        if (it.command == dmprt_pkg::CMD_DIGIT)
        begin
            if (it.first_digit)
            begin
                run_r1 = '0;
                run_r2 = '0;
            end
            run_r1 = dmprt_pkg::R1_W'(fold_digit(64'(run_r1), 64'(it.digit),
                                                 64'(dmprt_pkg::PRIME_FIRST)));
            run_r2 = dmprt_pkg::R2_W'(fold_digit(64'(run_r2), 64'(it.digit),
                                                 64'(dmprt_pkg::PRIME_SECOND)));
            if (it.last_digit)
            begin
                coeff_r1[it.coeff_index] = it.negative ?
                    dmprt_pkg::R1_W'(negate_mod(64'(run_r1), 64'(dmprt_pkg::PRIME_FIRST))) :
                    run_r1;
                coeff_r2[it.coeff_index] = it.negative ?
                    dmprt_pkg::R2_W'(negate_mod(64'(run_r2), 64'(dmprt_pkg::PRIME_SECOND))) :
                    run_r2;
                coeff_loaded[it.coeff_index] = 1'b1;
            end
        end
        else
        begin
            r1 = horner_mod(1'b1, int'(degree_q), 64'(it.point));
            r2 = horner_mod(1'b0, int'(degree_q), 64'(it.point));
            want.evaluated_point = it.point;
            want.is_root         = (r1 == 0) || (r2 == 0);
            want.residue_first   = dmprt_pkg::R1_W'(r1);
            want.residue_second  = dmprt_pkg::R2_W'(r2);
            pending_results.push_back(want);
        end
    endtask

    task automatic send_item(input dmprt_pkg::in_item_t it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        apply_item(it);
    endtask

    task automatic send_digit(input logic [dmprt_pkg::IDX_W-1:0] idx,
                              input logic [dmprt_pkg::DIGIT_W-1:0] d,
                              input bit first, input bit last, input bit neg);
        dmprt_pkg::in_item_t it;
        it.command     = dmprt_pkg::CMD_DIGIT;
        it.coeff_index = idx;
        it.digit       = d;
        it.first_digit = first;
        it.last_digit  = last;
        it.negative    = neg;
        it.point       = dmprt_pkg::POINT_W'($urandom);
        send_item(it);
    endtask

    task automatic send_eval(input logic [dmprt_pkg::POINT_W-1:0] x);
        dmprt_pkg::in_item_t it;
        it.command     = dmprt_pkg::CMD_EVAL;
        it.coeff_index = dmprt_pkg::IDX_W'($urandom);
        it.digit       = dmprt_pkg::DIGIT_W'($urandom);
        it.first_digit = 1'($urandom);
        it.last_digit  = 1'($urandom);
        it.negative    = 1'($urandom);
        it.point       = x;
        send_item(it);
    endtask

    task automatic load_coeff(input int idx, input int ndig, input bit zero_value);
        for (int k = 0; k < ndig; k++)
            send_digit((k == ndig - 1) ? dmprt_pkg::IDX_W'(idx) :
                                         dmprt_pkg::IDX_W'($urandom),
                       zero_value ? dmprt_pkg::DIGIT_W'(0) : rand_digit(),
                       k == 0, k == ndig - 1, 1'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_degree(input logic [dmprt_pkg::IDX_W-1:0] d);
        wait_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= d;
        @(posedge clk);
        degree_q = d;
        cfg_write_en <= 1'b0;
    endtask

    task automatic check_result(input dmprt_pkg::out_item_t got);
        dmprt_pkg::out_item_t want;
        if (pending_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
                $display("unexpected result: point %0d root %0b r1 %0d r2 %0d",
                         got.evaluated_point, got.is_root, got.residue_first,
                         got.residue_second);
            return;
        end
        want = pending_results.pop_front();
        if (got.evaluated_point !== want.evaluated_point || got.is_root !== want.is_root ||
            got.residue_first !== want.residue_first ||
            got.residue_second !== want.residue_second)
        begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
            begin
                $write("mismatch: expected point %0d root %0b r1 %0d r2 %0d, ",
                       want.evaluated_point, want.is_root, want.residue_first,
                       want.residue_second);
                $display("actual point %0d root %0b r1 %0d r2 %0d",
                         got.evaluated_point, got.is_root, got.residue_first,
                         got.residue_second);
            end
        end
    endtask

    // degree is zero out of reset
    task automatic test_constant_term();
        send_digit(7'd0, 4'd7, 1'b1, 1'b1, 1'b0);
        send_eval('0);
        // negative zero, root everywhere
        send_digit(7'd0, 4'd0, 1'b1, 1'b1, 1'b1);
        send_eval(20'hFFFFF);
    endtask

    task automatic test_linear_root();
        write_degree(7'd1);
        send_digit(7'd1, 4'd1, 1'b1, 1'b1, 1'b0);
        send_digit(7'd0, 4'd3, 1'b1, 1'b1, 1'b1);
        send_eval(20'd3);
        send_eval(20'hFFFFF);
    endtask

    task automatic test_long_coefficient();
        int unsigned long_digits [12] = '{9, 15, 9, 9, 15, 9, 9, 9, 15, 9, 9, 8};
        // wraps both primes, with digits above nine
        for (int k = 0; k < 12; k++)
            send_digit(7'd1, dmprt_pkg::DIGIT_W'(long_digits[k]), k == 0, k == 11, 1'b1);
        send_eval(20'd2);
    endtask

    task automatic test_digit_restart();
        send_digit(7'd0, 4'd5, 1'b1, 1'b0, 1'b0);
        send_digit(7'd0, 4'd15, 1'b1, 1'b1, 1'b1);
        send_eval(20'd7);
        send_digit(7'd127, 4'd4, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_random_polynomials();
        int deg;
        int n_eval;
        int pick;
        logic [dmprt_pkg::POINT_W-1:0] x;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_on = (ph < NUM_PHASES - 3);
            if (ph == 2 || ph == NUM_PHASES - 2)
                deg = 127;
            else if (ph == 5)
                deg = 0;
            else if (ph % 4 == 3)
                deg = $urandom_range(16, 127);
            else
                deg = $urandom_range(1, 12);
            n_eval = (deg > 15) ? 4 : 20;
            write_degree(dmprt_pkg::IDX_W'(deg));
            for (int j = 0; j <= deg; j++)
                if (!coeff_loaded[j] || $urandom_range(0, 3) == 0)
                    load_coeff(j, (deg > 15) ? $urandom_range(1, 2) : $urandom_range(1, 4),
                               $urandom_range(0, 7) == 0);
            // long result stall while items keep coming
            if (ph == 4)
                hold_req = 1'b1;
            for (int e = 0; e < n_eval; e++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    load_coeff($urandom_range(0, deg), $urandom_range(1, 4),
                               $urandom_range(0, 7) == 0);
                else if (pick == 4)
                    send_digit(dmprt_pkg::IDX_W'($urandom), rand_digit(), 1'($urandom),
                               1'($urandom), 1'($urandom));
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    x = '0;
                else if (pick == 1)
                    x = '1;
                else if (pick == 2)
                    x = 20'd1;
                else
                    x = dmprt_pkg::POINT_W'($urandom);
                send_eval(x);
            end
        end
    endtask

    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_result(out_item);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        in_valid       <= 1'b0;
        in_item        <= '0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        rst_n          <= 1'b0;
        degree_q = '0;
        run_r1   = '0;
        run_r2   = '0;
        for (int j = 0; j < NUM_COEFFS; j++)
        begin
            coeff_r1[j]     = '0;
            coeff_r2[j]     = '0;
            coeff_loaded[j] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_constant_term();
        test_linear_root();
        test_long_coefficient();
        test_digit_restart();
        test_random_polynomials();

        wait_idle();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* dual_modulus_polynomial_root_test.f */
design/dmprt_pkg.sv
design/dmprt_lane.sv
design/dmprt_coeff_store.sv
design/dmprt_seq.sv
design/dual_modulus_polynomial_root_test.sv
design/dmprt_checker.sv
tb/tb_dual_modulus_polynomial_root_test.sv
